// File: src/midi_message_framer_unit_assert.svh
// ----------------------------------------------------------------------------
// MIDI message framer - assertion macros
// Shared property wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define MIDI_MESSAGE_FRAMER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define MMF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define MMF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/mmf_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message framer - package
// Shared constants, length tables, queue command and sequencer state types.
// ----------------------------------------------------------------------------
package mmf_pkg;

	localparam int BUF_BYTES_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int IDX_W         = 5;

	localparam logic [IDX_W-1:0] IDX_MAX      = 5'd31;
	localparam logic [7:0]       STATUS_MIN   = 8'h80;
	localparam logic [7:0]       REALTIME_MIN = 8'hf8;
	localparam logic [7:0]       SYSTEM_MIN   = 8'hf0;

	typedef logic [1:0] len_t;

	// one queue entry: the actions the back end runs for one item, in order
	typedef struct packed {
		logic       flush_pre;
		logic       app_rs;
		logic       app_c;
		logic       flush_post;
		logic       emit_rt;
		logic [7:0] rs_byte;
		logic [7:0] c_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_PRE,
		SQ_RS,
		SQ_C,
		SQ_POST,
		SQ_RT
	} seq_state_t;

	// message length by status bits 6..4 (channel voice)
	function automatic len_t chan_msg_len(input logic [2:0] sel);
		len_t l;
		case (sel)
			3'd4, 3'd5: l = 2'd2;
			3'd7:       l = 2'd0;
			default:    l = 2'd3;
		endcase
		return l;
	endfunction

	// message length by status bits 2..0 (system common)
	function automatic len_t sys_msg_len(input logic [2:0] sel);
		len_t l;
		case (sel)
			3'd1, 3'd3: l = 2'd2;
			3'd2:       l = 2'd3;
			3'd6, 3'd7: l = 2'd1;
			default:    l = 2'd0;
		endcase
		return l;
	endfunction

endpackage

// File: src/midi_message_framer_unit.sv
// ----------------------------------------------------------------------------
// MIDI message framer unit - top level
// Rebuilds MIDI messages with running status and emits them as byte bursts.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  --------------------------
//  in       sink       in_valid / in_stall    in_byte
//  out      source     out_valid / out_stall  out_byte, last_of_run
//
// Flow: the front end takes a byte whenever its command queue has room.
// The back sequencer takes each item through PRE, RS, C, POST and RT;
// a flush stays in PRE or POST until every buffered byte is read. The
// buffer's single read port sets the one byte per cycle drain rate while
// the output buffer has room; a read byte passes s1 into that buffer.
// Reset: asynchronous, clears all control state; the message buffer is not
// cleared, only entries written since the last flush are read back.
// Stalls: out_stall holds the output buffer and, through it, the flush;
// in_stall rises only when the command queue is full.
//
`include "midi_message_framer_unit_assert.svh"

module midi_message_framer_unit #(
	parameter int BUF_BYTES = mmf_pkg::BUF_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	localparam int FILL_W = $clog2(BUF_BYTES + 1);
	localparam logic [FILL_W-1:0] BUF_FILL = FILL_W'(BUF_BYTES);

	// front to queue
	logic          q_push, q_full;
	mmf_pkg::cmd_t q_push_cmd;
	// queue to back
	logic          q_pop, q_empty;
	mmf_pkg::cmd_t q_pop_cmd;

	logic [FILL_W-1:0] front_fill, back_fill;
	logic              back_idle;

	// classification, running status and framing decisions
	mmf_front #(
		.BUF_BYTES(BUF_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_push_cmd),
		.fill     (front_fill)
	);

	// decouples the byte intake from long flush bursts
	mmf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.empty    (q_empty)
	);

	// buffer owner: appends, flushes and realtime pass-through
	mmf_back #(
		.BUF_BYTES(BUF_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (q_pop_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.idle        (back_idle),
		.fill        (back_fill)
	);

	// once all queued work is done, both ends agree on the buffer fill
	`MMF_ASSERT_IMPLIES(a_fill_in_step, q_empty && back_idle, front_fill == back_fill, "fill mismatch")

	// a full buffer is always flushed within the item that filled it
	`MMF_ASSERT_ALWAYS(a_fill_below_buf, front_fill < BUF_FILL, "buffer left full between items")

	// the back end never appends past the end of the buffer
	`MMF_ASSERT_ALWAYS(a_back_fill_bound, back_fill <= BUF_FILL, "back end buffer pointer overrun")

endmodule

// File: src/mmf_front.sv
// ----------------------------------------------------------------------------
// MIDI message framer - front end
// Classifies each byte, tracks running status and framing, queues commands.
// ----------------------------------------------------------------------------
module mmf_front #(
	parameter int BUF_BYTES = mmf_pkg::BUF_BYTES_DEF,
	localparam int FILL_W = $clog2(BUF_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               q_full,
	output logic               q_push,
	output mmf_pkg::cmd_t      q_cmd,
	output logic [FILL_W-1:0]  fill
);

	localparam logic [FILL_W-1:0] BUF_FILL = FILL_W'(BUF_BYTES);

	logic [FILL_W-1:0]         fill_q, fill_d;
	logic [mmf_pkg::IDX_W-1:0] idx_q, idx_d;
	mmf_pkg::len_t             exp_q, exp_d, len;
	logic [7:0]                rs_q, rs_d;
	mmf_pkg::cmd_t             cmd;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_cmd    = cmd;
	assign fill     = fill_q;

	assign len = (in_byte >= mmf_pkg::SYSTEM_MIN) ? mmf_pkg::sys_msg_len(in_byte[2:0])
	                                              : mmf_pkg::chan_msg_len(in_byte[6:4]);

	always_comb begin
		cmd         = '0;
		cmd.rs_byte = rs_q;
		cmd.c_byte  = in_byte;
		fill_d      = fill_q;
		idx_d       = idx_q;
		exp_d       = exp_q;
		rs_d        = rs_q;
		if (in_byte < mmf_pkg::STATUS_MIN) begin
			// data: reinsert running status at message start
			if (idx_q == '0 && rs_q != '0) begin
				cmd.app_rs = (fill_d < BUF_FILL);
				if (cmd.app_rs)
					fill_d = fill_d + FILL_W'(1);
				if (idx_d != mmf_pkg::IDX_MAX)
					idx_d = idx_d + 5'd1;
			end
			cmd.app_c = (fill_d < BUF_FILL);
			if (cmd.app_c)
				fill_d = fill_d + FILL_W'(1);
			if (idx_d != mmf_pkg::IDX_MAX)
				idx_d = idx_d + 5'd1;
			if (idx_d == mmf_pkg::IDX_W'(exp_q)) begin
				cmd.flush_post = 1'b1;
				fill_d         = '0;
				idx_d          = '0;
				if (rs_q >= mmf_pkg::SYSTEM_MIN)
					rs_d = '0;
			end else if (fill_d >= BUF_FILL) begin
				cmd.flush_post = 1'b1;
				fill_d         = '0;
			end
		end else if (in_byte < mmf_pkg::REALTIME_MIN) begin
			cmd.app_c = 1'b1;
			if (len == 2'd1) begin
				// single-byte message: goes out behind the pending bytes
				cmd.flush_post = 1'b1;
				fill_d         = '0;
				idx_d          = '0;
				rs_d           = '0;
				exp_d          = '0;
			end else begin
				cmd.flush_pre = 1'b1;
				fill_d        = FILL_W'(1);
				idx_d         = 5'd1;
				rs_d          = in_byte;
				exp_d         = len;
			end
		end else begin
			cmd.emit_rt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
			exp_q  <= '0;
			rs_q   <= '0;
		end else if (q_push) begin
			fill_q <= fill_d;
			idx_q  <= idx_d;
			exp_q  <= exp_d;
			rs_q   <= rs_d;
		end
	end

endmodule

// File: src/mmf_cmd_queue.sv
// ----------------------------------------------------------------------------
// MIDI message framer - command queue
// Short FIFO of commands between front and back ends.
// ----------------------------------------------------------------------------
module mmf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mmf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output mmf_pkg::cmd_t pop_cmd,
	output logic          empty
);

	localparam int DEPTH = mmf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mmf_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[tail_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
			if (pop)
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: src/mmf_back.sv
// ----------------------------------------------------------------------------
// MIDI message framer - back end
// Sequences queued commands over the message buffer and drives the output.
// ----------------------------------------------------------------------------
module mmf_back #(
	parameter int BUF_BYTES = mmf_pkg::BUF_BYTES_DEF,
	localparam int FILL_W = $clog2(BUF_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  mmf_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_run,
	output logic              idle,
	output logic [FILL_W-1:0] fill
);

	localparam int AW      = $clog2(BUF_BYTES);
	localparam int OUT_DEP = 2;
	localparam int OP_W    = $clog2(OUT_DEP);
	localparam int OCC_W   = $clog2(OUT_DEP + 1);

	mmf_pkg::seq_state_t state_q, state_d;
	mmf_pkg::cmd_t       cmd_q, cmd_d;
	logic [FILL_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;

	logic [7:0] mem [BUF_BYTES];
	logic       mem_we;
	logic [7:0] mem_wd;

	logic       issue, issue_mem, issue_last, rd_last;
	logic       s1_valid_s1, s1_mem_s1, s1_last_s1;
	logic [7:0] s1_byte_s1, rd_data_s1, push_byte;

	logic [7:0]       ob_byte_q [OUT_DEP];
	logic             ob_last_q [OUT_DEP];
	logic [OP_W-1:0]  ob_head_q, ob_tail_q;
	logic [OCC_W-1:0] ob_occ_q;
	logic [OCC_W:0]   used;
	logic             out_pop, can_issue;

	assign out_valid   = (ob_occ_q != '0);
	assign out_byte    = ob_byte_q[ob_head_q];
	assign last_of_run = ob_last_q[ob_head_q];
	assign out_pop     = out_valid && !out_stall;

	// slots taken in the output buffer once this cycle settles
	assign used      = (OCC_W+1)'(ob_occ_q) + (OCC_W+1)'(s1_valid_s1) - (OCC_W+1)'(out_pop);
	assign can_issue = (used < (OCC_W+1)'(OUT_DEP));
	assign rd_last   = (rd_ptr_q + FILL_W'(1) == wr_ptr_q);

	assign idle = (state_q == mmf_pkg::SQ_IDLE);
	assign fill = wr_ptr_q;

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		q_pop      = 1'b0;
		issue      = 1'b0;
		issue_mem  = 1'b0;
		issue_last = 1'b0;
		mem_we     = 1'b0;
		mem_wd     = cmd_q.c_byte;
		case (state_q)
			mmf_pkg::SQ_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					cmd_d   = q_cmd;
					state_d = mmf_pkg::SQ_PRE;
				end
			end
			mmf_pkg::SQ_PRE, mmf_pkg::SQ_POST: begin
				if ((state_q == mmf_pkg::SQ_PRE ? cmd_q.flush_pre : cmd_q.flush_post)
				    && wr_ptr_q != '0) begin
					if (can_issue) begin
						issue      = 1'b1;
						issue_mem  = 1'b1;
						issue_last = rd_last;
						if (rd_last) begin
							rd_ptr_d = '0;
							wr_ptr_d = '0;
							state_d  = (state_q == mmf_pkg::SQ_PRE) ? mmf_pkg::SQ_RS
							                                        : mmf_pkg::SQ_RT;
						end else begin
							rd_ptr_d = rd_ptr_q + FILL_W'(1);
						end
					end
				end else begin
					state_d = (state_q == mmf_pkg::SQ_PRE) ? mmf_pkg::SQ_RS : mmf_pkg::SQ_RT;
				end
			end
			mmf_pkg::SQ_RS: begin
				if (cmd_q.app_rs) begin
					mem_we   = 1'b1;
					mem_wd   = cmd_q.rs_byte;
					wr_ptr_d = wr_ptr_q + FILL_W'(1);
				end
				state_d = mmf_pkg::SQ_C;
			end
			mmf_pkg::SQ_C: begin
				if (cmd_q.app_c) begin
					mem_we   = 1'b1;
					wr_ptr_d = wr_ptr_q + FILL_W'(1);
				end
				state_d = mmf_pkg::SQ_POST;
			end
			mmf_pkg::SQ_RT: begin
				if (!cmd_q.emit_rt) begin
					state_d = mmf_pkg::SQ_IDLE;
				end else if (can_issue) begin
					issue      = 1'b1;
					issue_last = 1'b1;
					state_d    = mmf_pkg::SQ_IDLE;
				end
			end
			default: state_d = mmf_pkg::SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mmf_pkg::SQ_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			state_q  <= state_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
	end

	// message buffer: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_ptr_q[AW-1:0]] <= mem_wd;
		if (issue_mem)
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else
			s1_valid_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		s1_mem_s1  <= issue_mem;
		s1_last_s1 <= issue_last;
		s1_byte_s1 <= cmd_q.c_byte;
	end

	assign push_byte = s1_mem_s1 ? rd_data_s1 : s1_byte_s1;

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			ob_byte_q[ob_tail_q] <= push_byte;
			ob_last_q[ob_tail_q] <= s1_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_head_q <= '0;
			ob_tail_q <= '0;
			ob_occ_q  <= '0;
		end else begin
			if (s1_valid_s1)
				ob_tail_q <= (ob_tail_q == OP_W'(OUT_DEP - 1)) ? '0 : ob_tail_q + OP_W'(1);
			if (out_pop)
				ob_head_q <= (ob_head_q == OP_W'(OUT_DEP - 1)) ? '0 : ob_head_q + OP_W'(1);
			if (s1_valid_s1 && !out_pop)
				ob_occ_q <= ob_occ_q + OCC_W'(1);
			else if (out_pop && !s1_valid_s1)
				ob_occ_q <= ob_occ_q - OCC_W'(1);
		end
	end

endmodule
